// ----- rtl/core/block_coefficient_quantizer_assert.svh -----
// Assertion macros used by the coefficient quantizer back end.
`ifndef BLOCK_COEFFICIENT_QUANTIZER_ASSERT_SVH
`define BLOCK_COEFFICIENT_QUANTIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define BCQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define BCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bcq_pkg.sv -----
// Shared types, operation codes and weighting matrices of the coefficient quantizer.
package bcq_pkg;

  // Operation codes on func
  typedef enum logic [3:0] {
    FN_Q_INTRA_LUMA   = 4'd0,
    FN_Q_INTRA_CHROMA = 4'd1,
    FN_Q_INTRA_LIN    = 4'd2,
    FN_Q_INTER        = 4'd3,
    FN_Q_INTER_LIN    = 4'd4,
    FN_DQ_LUMA        = 4'd5,
    FN_DQ_CHROMA      = 4'd6,
    FN_DQ_LIN         = 4'd7,
    FN_DQ_INTER       = 4'd8,
    FN_DQ_FLAT        = 4'd9
  } func_e;

  // Work class that the back end carries out
  typedef enum logic [2:0] {
    CL_ZERO  = 3'd0,  // result is zero
    CL_DIV1  = 3'd1,  // one reciprocal divide
    CL_DIV2  = 3'd2,  // two chained divides
    CL_DZ    = 3'd3,  // divide, dead-zone subtract, divide
    CL_PLAIN = 3'd4,  // product as is
    CL_SHIFT = 3'd5,  // product over eight
    CL_LIN   = 3'd6   // product minus even-step correction
  } cls_e;

  localparam int RecipShift = 26;

  // One classified item as it waits in the queue
  typedef struct packed {
    cls_e        cls;
    logic        neg;
    logic        ev;
    logic [4:0]  step;
    logic [19:0] opa;
    logic [25:0] opb;
    logic [25:0] recip2;
  } item_t;

  localparam logic [5:0] INTRA_QM [64] = '{
    6'd8,  6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd27,
    6'd17, 6'd18, 6'd19, 6'd21, 6'd23, 6'd25, 6'd27, 6'd28,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32,
    6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35,
    6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38,
    6'd25, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38, 6'd41,
    6'd27, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38, 6'd41, 6'd45
  };

  localparam logic [5:0] INTER_QM [64] = '{
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
    6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd27,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd25, 6'd26, 6'd27, 6'd28,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd27, 6'd28, 6'd30,
    6'd22, 6'd23, 6'd24, 6'd26, 6'd27, 6'd28, 6'd30, 6'd31,
    6'd23, 6'd24, 6'd25, 6'd27, 6'd28, 6'd30, 6'd31, 6'd33
  };

endpackage

// ----- rtl/core/bcq_fifo.sv -----
// Two-entry queue between the classifying front end and the arithmetic back end.
module bcq_fifo
  import bcq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t pop_data_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q[1];
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/bcq_front.sv -----
// Front end: accepts an input beat, decodes the operation and sets up the operands.
module bcq_front
  import bcq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [3:0]   func_i,
  input  logic [4:0]   step_i,
  input  logic [5:0]   position_i,
  input  logic signed [15:0] coefficient_i,
  output logic         push_o,
  input  logic         full_i,
  output item_t        item_o
);

  logic [25:0] recip_tab [64];

  // Reciprocal table: ceil(2^26 / d) for d of 2 and above (zero for 0 and 1), exact for numerators under 2^20
  for (genvar g = 0; g < 64; g++) begin : g_recip
    localparam logic [25:0] RV = (g < 2) ? 26'd0 :
      26'(((2 ** RecipShift) + g - 1) / ((g < 2) ? 1 : g));
    assign recip_tab[g] = RV;
  end

  logic        vld_q, vld_d;
  item_t       item_q, item_d;
  logic        load;
  logic [16:0] mag;
  logic        sgn_neg;
  logic        coef_zero;
  logic [5:0]  qm_intra, qm_inter, qm_sel;
  logic [10:0] qm_step;
  logic [5:0]  dc_luma, dc_chroma, dc_sel;
  logic [5:0]  two_step;
  logic signed [17:0] lin_t;
  logic [17:0] lin_abs;
  logic [5:0]  chroma_mid;

  assign in_ready_o = !vld_q || !full_i;
  assign load       = in_valid_i && in_ready_o;
  assign push_o     = vld_q && !full_i;
  assign item_o     = item_q;

  // Magnitude, sign and table lookups
  always_comb begin
    sgn_neg   = coefficient_i[15];
    coef_zero = (coefficient_i == 16'sd0);
    mag       = sgn_neg ? 17'(-{coefficient_i[15], coefficient_i})
                        : 17'({coefficient_i[15], coefficient_i});
    qm_intra  = INTRA_QM[position_i];
    qm_inter  = INTER_QM[position_i];
    qm_sel    = ((func_i == FN_Q_INTER) || (func_i == FN_DQ_INTER)) ? qm_inter : qm_intra;
    qm_step   = 11'(qm_sel * step_i);
    two_step  = {step_i, 1'b0};
    chroma_mid = 6'(({1'b0, step_i} + 6'd13) >> 1);
    if (step_i < 5'd5) begin
      dc_luma   = 6'd8;
      dc_chroma = 6'd8;
    end else if (step_i < 5'd9) begin
      dc_luma   = two_step;
      dc_chroma = chroma_mid;
    end else if (step_i < 5'd25) begin
      dc_luma   = {1'b0, step_i} + 6'd8;
      dc_chroma = chroma_mid;
    end else begin
      dc_luma   = two_step - 6'd16;
      dc_chroma = {1'b0, step_i} - 6'd6;
    end
    dc_sel  = (func_i == FN_Q_INTRA_CHROMA || func_i == FN_DQ_CHROMA) ? dc_chroma : dc_luma;
    lin_t   = $signed({1'b0, mag}) - $signed({14'd0, step_i[4:1]});
    lin_abs = lin_t[17] ? 18'(-lin_t) : 18'(lin_t);
  end

  // Classify the operation
  always_comb begin
    item_d        = item_q;
    if (load) begin
      item_d.cls    = CL_ZERO;
      item_d.neg    = sgn_neg;
      item_d.ev     = !step_i[0];
      item_d.step   = step_i;
      item_d.opa    = 20'({mag, 4'b0000});
      item_d.opb    = recip_tab[qm_sel];
      item_d.recip2 = recip_tab[two_step];
      case (func_i)
        FN_Q_INTRA_LUMA, FN_Q_INTRA_CHROMA: begin
          if (position_i == 6'd0) begin
            item_d.cls = CL_DIV1;
            item_d.opa = 20'(mag);
            item_d.opb = recip_tab[dc_sel];
          end else if (step_i != 5'd0) begin
            item_d.cls = CL_DIV2;
          end
        end
        FN_Q_INTRA_LIN: begin
          if (step_i != 5'd0) begin
            item_d.cls = CL_DIV1;
            item_d.opa = 20'(mag);
            item_d.opb = recip_tab[two_step];
          end
        end
        FN_Q_INTER: begin
          if (step_i != 5'd0) begin
            item_d.cls = CL_DZ;
          end
        end
        FN_Q_INTER_LIN: begin
          if (step_i != 5'd0) begin
            item_d.cls = CL_DIV1;
            item_d.neg = sgn_neg ^ lin_t[17];
            item_d.opa = 20'(lin_abs);
            item_d.opb = recip_tab[two_step];
          end
        end
        FN_DQ_LUMA, FN_DQ_CHROMA: begin
          item_d.opa = 20'(mag);
          if (position_i == 6'd0) begin
            item_d.cls = CL_PLAIN;
            item_d.opb = 26'(dc_sel);
          end else begin
            item_d.cls = CL_SHIFT;
            item_d.opb = 26'(qm_step);
          end
        end
        FN_DQ_LIN: begin
          if (!coef_zero) begin
            item_d.cls = CL_LIN;
            item_d.opa = 20'({mag, 1'b1});
            item_d.opb = 26'(step_i);
          end
        end
        FN_DQ_INTER: begin
          item_d.cls = CL_SHIFT;
          item_d.opa = 20'(mag);
          item_d.opb = 26'(qm_step);
        end
        FN_DQ_FLAT: begin
          item_d.cls = CL_PLAIN;
          item_d.opa = 20'(mag);
          item_d.opb = 26'(step_i);
        end
        default: begin
          item_d.cls = CL_ZERO;
        end
      endcase
    end
  end

  // Hold the beat until the queue takes it
  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ----- rtl/core/bcq_back.sv -----
// Back end: three-stage multiply, reciprocal divide and sign pipeline with output register.
module bcq_back
  import bcq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fifo_valid_i,
  output logic        pop_o,
  input  item_t       item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] value_o
);

`include "block_coefficient_quantizer_assert.svh"

  logic        adv;
  logic        v1_q, v2_q, v3_q;
  // Stage 1
  cls_e        cls1_q;
  logic        neg1_q, ev1_q;
  logic [4:0]  step1_q;
  logic [25:0] recip1_q;
  logic [45:0] p1_q, p1_d;
  // Stage 2
  cls_e        cls2_q;
  logic        neg2_q, neg2_d;
  logic [15:0] mag2_q, mag2_d;
  logic [42:0] p2_q, p2_d;
  logic [16:0] q1;
  logic signed [17:0] dz_u;
  logic [16:0] n2;
  // Stage 3
  cls_e        cls3_q;
  logic [15:0] mag3;
  logic [15:0] value_q, value_d;

  assign adv         = !v3_q || out_ready_i;
  assign pop_o       = adv && fifo_valid_i;
  assign out_valid_o = v3_q;
  assign value_o     = value_q;

  // Stage 1: shared multiplier, product or reciprocal divide
  assign p1_d = 46'(item_i.opa * item_i.opb);

  // Stage 2: first quotient, dead-zone subtract, second divide, result select for the other classes
  always_comb begin
    q1     = p1_q[RecipShift +: 17];
    dz_u   = $signed({1'b0, q1}) - $signed({13'd0, step1_q});
    n2     = (cls1_q == CL_DZ) ? (dz_u[17] ? 17'(-dz_u) : 17'(dz_u)) : q1;
    neg2_d = (cls1_q == CL_DZ) ? (neg1_q ^ dz_u[17]) : neg1_q;
    p2_d   = 43'(n2 * recip1_q);
    case (cls1_q)
      CL_DIV1:  mag2_d = q1[15:0];
      CL_PLAIN: mag2_d = p1_q[15:0];
      CL_SHIFT: mag2_d = p1_q[18:3];
      CL_LIN:   mag2_d = p1_q[15:0] - {15'd0, ev1_q};
      default:  mag2_d = 16'd0;
    endcase
  end

  // Stage 3: second quotient and sign
  always_comb begin
    mag3    = ((cls2_q == CL_DIV2) || (cls2_q == CL_DZ)) ? p2_q[RecipShift +: 16] : mag2_q;
    value_d = neg2_q ? 16'(-mag3) : mag3;
  end

  // Advance valid bits on a free output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= fifo_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls1_q   <= item_i.cls;
      neg1_q   <= item_i.neg;
      ev1_q    <= item_i.ev;
      step1_q  <= item_i.step;
      recip1_q <= item_i.recip2;
      p1_q     <= p1_d;
      cls2_q   <= cls1_q;
      neg2_q   <= neg2_d;
      mag2_q   <= mag2_d;
      p2_q     <= p2_d;
      cls3_q   <= cls2_q;
      value_q  <= value_d;
    end
  end

  `BCQ_ASSERT_NEXT(a_stage1_moves, v1_q && adv, v2_q, "stage 1 beat lost")
  `BCQ_ASSERT_NEXT(a_stage2_moves, v2_q && adv, v3_q, "stage 2 beat lost")
  `BCQ_ASSERT_NOW(a_zero_class, v3_q && (cls3_q == CL_ZERO), value_q == 16'd0, "zero class nonzero")

endmodule

// ----- rtl/core/block_coefficient_quantizer.sv -----
// Top level of the 8x8 coefficient quantizer and dequantizer.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i / in_ready_o func_i, step_i, position_i, coefficient_i
//   result    out        out_valid_o / out_ready_i value_o
//
// One beat per cycle sustained while out_ready_i stays high; an accepted input beat passes
// through the front register (loaded on the edge that accepts it), then queue, multiply stage,
// divide stage and output register, whose load raises out_valid_o.
// Each divide is a multiply by a stored reciprocal; the shared multiplier per stage sets the depth.
// Reset clears the front, queue and pipeline valid bits; no result is pending after it.
// A stalled output freezes the back pipeline; the front keeps accepting until its register
// and the two-entry queue hold three beats, then drops in_ready_o.
module block_coefficient_quantizer
  import bcq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  func_i,
  input  logic [4:0]  step_i,
  input  logic [5:0]  position_i,
  input  logic signed [15:0] coefficient_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] value_o
);

  logic  push, full, fifo_valid, pop;
  item_t front_item, queue_item;

  bcq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .step_i       (step_i),
    .position_i   (position_i),
    .coefficient_i(coefficient_i),
    .push_o       (push),
    .full_i       (full),
    .item_o       (front_item)
  );

  bcq_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_item),
    .full_o     (full),
    .valid_o    (fifo_valid),
    .pop_i      (pop),
    .pop_data_o (queue_item)
  );

  bcq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_valid_i(fifo_valid),
    .pop_o       (pop),
    .item_i      (queue_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

endmodule
